// File: hw/rtl/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Types and constants for the sorted interval table.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int DEPTH = 32;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [2:0] REQ_INSERT  = 3'd0;
    localparam logic [2:0] REQ_REMOVE  = 3'd1;
    localparam logic [2:0] REQ_POINT   = 3'd2;
    localparam logic [2:0] REQ_OVERLAP = 3'd3;
    localparam logic [2:0] REQ_CUT     = 3'd4;

    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] hi;
        logic [31:0] lo;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_CHK,
        ST_DISPATCH,
        ST_CUT_RD,
        ST_CUT_CHK,
        ST_ID_RD,
        ST_ID_CHK,
        ST_DEL,
        ST_DEL_WR,
        ST_INS,
        ST_INS_WR,
        ST_OUT
    } t_state;

endpackage

// File: hw/rtl/sorted_interval_table.sv
// ----------------------------------------------------------------------------
// sorted_interval_table
// Table of closed intervals sorted by start, held in one entry memory.
// ----------------------------------------------------------------------------
// An unknown request or an insert into a full table goes straight to the result;
// a lookup scans entries from the bottom up past each one at or below the key,
// and an insert or delete then shifts the entries above its place. A cut walks
// down from the last entry at or below its end and deletes each entry it covers.
// Throughput: one request at a time; a new word is taken while a result waits.
// Reset: synchronous, active low; clears fill count and control, not the memory.
module sorted_interval_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // range_start[31:0], range_end[63:32], entry_id[95:64], split_id[127:96]
    input  logic [127:0] i_s_tdata,
    // req_type[2:0]
    input  logic [2:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // hit[0], found_id[32:1], found_start[64:33], found_end[96:65],
    // entry_count[102:97], zero[103]
    output logic [103:0] o_m_tdata,
    // status[1:0]
    output logic [1:0]   o_m_tuser
);
    import sit_pkg::*;

    t_entry mem [DEPTH];
    t_entry r_rdata;
    logic [AW-1:0] mem_raddr, mem_waddr;
    logic          mem_we;
    t_entry        mem_wdata;

    t_state r_state, n_state;
    logic [2:0]    r_op, n_op;
    logic [31:0]   r_s, n_s, r_e, n_e, r_id, n_id, r_sid, n_sid, r_key, n_key;
    logic [CW-1:0] r_cnt, n_cnt, r_idx, n_idx, r_k, n_k, r_ipos, n_ipos;
    t_entry        r_prev, n_prev, r_next, n_next, r_new, n_new, r_found, n_found;
    logic          r_walk, n_walk, r_hit, n_hit;
    logic [1:0]    r_status, n_status;
    logic          r_ovalid, n_ovalid;
    logic [103:0]  r_odata, n_odata;
    logic [1:0]    r_ouser, n_ouser;
    logic [CW-1:0] k_inc;
    logic          ov_hit;
    t_entry        cur;

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[mem_raddr];
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
        r_op <= n_op;   r_s <= n_s;     r_e <= n_e;       r_id <= n_id;
        r_sid <= n_sid; r_key <= n_key; r_idx <= n_idx;   r_k <= n_k;
        r_ipos <= n_ipos; r_prev <= n_prev; r_next <= n_next; r_new <= n_new;
        r_found <= n_found; r_walk <= n_walk; r_hit <= n_hit;
        r_status <= n_status; r_odata <= n_odata; r_ouser <= n_ouser;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

    always_comb begin
        n_state = r_state;  n_op = r_op;   n_s = r_s;     n_e = r_e;
        n_id = r_id;        n_sid = r_sid; n_key = r_key; n_cnt = r_cnt;
        n_idx = r_idx;      n_k = r_k;     n_ipos = r_ipos;
        n_prev = r_prev;    n_next = r_next; n_new = r_new; n_found = r_found;
        n_walk = r_walk;    n_hit = r_hit; n_status = r_status;
        n_ovalid = r_ovalid; n_odata = r_odata; n_ouser = r_ouser;
        mem_raddr = r_idx[AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = r_idx[AW-1:0];
        mem_wdata = r_rdata;
        cur       = r_rdata;
        k_inc     = r_k + 1'b1;
        ov_hit    = 1'b0;

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_op     = i_s_tuser;
                    n_s      = i_s_tdata[31:0];
                    n_e      = i_s_tdata[63:32];
                    n_id     = i_s_tdata[95:64];
                    n_sid    = i_s_tdata[127:96];
                    n_status = STAT_DONE;
                    n_hit    = 1'b0;
                    n_found  = '0;
                    n_idx    = '0;
                    n_walk   = 1'b0;
                    n_key    = i_s_tdata[31:0];
                    case (i_s_tuser)
                        REQ_INSERT: begin
                            if (r_cnt >= CW'(DEPTH)) begin
                                n_status = STAT_FULL;
                                n_state  = ST_OUT;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        REQ_REMOVE, REQ_POINT, REQ_OVERLAP: n_state = ST_SCAN;
                        REQ_CUT: begin
                            n_key   = i_s_tdata[63:32];
                            n_state = ST_SCAN;
                        end
                        default: n_state = ST_OUT;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_idx == r_cnt) begin
                    n_state = ST_DISPATCH;
                end else begin
                    n_state = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: begin
                if (r_rdata.lo <= r_key) begin
                    n_prev  = r_rdata;
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_SCAN;
                end else begin
                    n_next  = r_rdata;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_state = ST_OUT;
                case (r_op)
                    REQ_INSERT: begin
                        n_ipos  = r_idx;
                        n_k     = r_cnt;
                        n_new   = '{id: r_id, hi: r_e, lo: r_s};
                        n_state = ST_INS;
                    end
                    REQ_REMOVE: begin
                        if (r_idx != '0 && r_prev.id == r_id) begin
                            n_hit   = 1'b1;
                            n_k     = r_idx - 1'b1;
                            n_state = ST_DEL;
                        end else begin
                            n_status = STAT_NOT_FOUND;
                        end
                    end
                    REQ_POINT: begin
                        if (r_idx != '0 && r_prev.hi >= r_s) begin
                            n_hit   = 1'b1;
                            n_found = r_prev;
                        end else begin
                            n_status = STAT_NOT_FOUND;
                        end
                    end
                    REQ_OVERLAP: begin
                        if (r_cnt == '0) begin
                            ov_hit = 1'b0;
                        end else if (r_idx == r_cnt) begin
                            ov_hit = r_prev.hi >= r_s;
                        end else if (r_idx == '0) begin
                            ov_hit = r_next.lo <= r_e;
                        end else begin
                            ov_hit = (r_prev.hi >= r_s) || (r_next.lo <= r_e);
                        end
                        n_hit = ov_hit;
                        if (!ov_hit) begin
                            n_status = STAT_NOT_FOUND;
                        end
                    end
                    REQ_CUT: begin
                        if (r_idx != '0) begin
                            n_idx   = r_idx - 1'b1;
                            n_state = ST_CUT_RD;
                        end
                    end
                    default: n_state = ST_OUT;
                endcase
            end
            ST_CUT_RD: begin
                n_state = ST_CUT_CHK;
            end
            ST_CUT_CHK: begin
                if (cur.hi < r_s) begin
                    n_idx   = '0;
                    n_state = ST_ID_RD;
                end else if (cur.hi > r_e) begin
                    if (cur.lo >= r_s) begin
                        // trim the left part away, then step down
                        mem_we       = 1'b1;
                        mem_wdata.lo = r_e + 1'b1;
                        if (r_idx == '0) begin
                            n_state = ST_ID_RD;
                        end else begin
                            n_idx   = r_idx - 1'b1;
                            n_state = ST_CUT_RD;
                        end
                    end else if (r_cnt >= CW'(DEPTH)) begin
                        n_status = STAT_FULL;
                        n_state  = ST_OUT;
                    end else begin
                        // split: keep left piece here, insert right piece above
                        mem_we       = 1'b1;
                        mem_wdata.hi = r_s - 1'b1;
                        n_new        = '{id: r_sid, hi: cur.hi, lo: r_e + 1'b1};
                        n_ipos       = r_idx + 1'b1;
                        n_k          = r_cnt;
                        n_state      = ST_INS;
                    end
                end else if (cur.lo >= r_s) begin
                    n_k     = r_idx;
                    n_walk  = 1'b1;
                    n_state = ST_DEL;
                end else begin
                    mem_we       = 1'b1;
                    mem_wdata.hi = r_s - 1'b1;
                    n_state      = ST_OUT;
                end
            end
            ST_ID_RD: begin
                if (r_idx == r_cnt) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_ID_CHK;
                end
            end
            ST_ID_CHK: begin
                if (r_rdata.id == r_id) begin
                    n_hit   = 1'b1;
                    n_k     = r_idx;
                    n_walk  = 1'b0;
                    n_state = ST_DEL;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_ID_RD;
                end
            end
            ST_DEL: begin
                mem_raddr = k_inc[AW-1:0];
                if (k_inc < r_cnt) begin
                    n_state = ST_DEL_WR;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                    if (!r_walk) begin
                        n_state = ST_OUT;
                    end else if (r_idx == '0) begin
                        n_state = ST_ID_RD;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = ST_CUT_RD;
                    end
                end
            end
            ST_DEL_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_k[AW-1:0];
                n_k       = k_inc;
                n_state   = ST_DEL;
            end
            ST_INS: begin
                mem_raddr = AW'(r_k - 1'b1);
                if (r_k > r_ipos) begin
                    n_state = ST_INS_WR;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_ipos[AW-1:0];
                    mem_wdata = r_new;
                    n_cnt     = r_cnt + 1'b1;
                    n_state   = ST_OUT;
                end
            end
            ST_INS_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_k[AW-1:0];
                n_k       = r_k - 1'b1;
                n_state   = ST_INS;
            end
            ST_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_ouser  = r_status;
                    n_odata  = {1'b0, 6'(r_cnt), r_found.hi, r_found.lo,
                                r_found.id, r_hit};
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (r_state == ST_SCAN || r_state == ST_ID_RD || r_state == ST_CUT_RD) begin
            mem_raddr = r_idx[AW-1:0];
        end
    end

endmodule
